// ===== hw/rtl/vec4_arith_unit_assert.svh =====
// ----------------------------------------------------------------------------
// vec4_arith_unit_assert.svh
// Assertion macros used by the vector ALU checker.
// ----------------------------------------------------------------------------
`ifndef VEC4_ARITH_UNIT_ASSERT_SVH
`define VEC4_ARITH_UNIT_ASSERT_SVH

// same-cycle implication
`define V4A_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define V4A_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/v4a_pkg.sv =====
// ----------------------------------------------------------------------------
// v4a_pkg
// Types, constants and helpers of the four-component vector ALU.
// ----------------------------------------------------------------------------
package v4a_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_W      = 32 + FRAC_BITS;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 33;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE   = 32'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_NEG   = 4'd2,
    CMD_MUL   = 4'd3,
    CMD_DIV   = 4'd4,
    CMD_DOT   = 4'd5,
    CMD_CROSS = 4'd6,
    CMD_MAG   = 4'd7,
    CMD_NORM  = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] a_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] b_w;
    logic signed [31:0] factor;
  } item_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_w;
    logic signed [31:0] scalar_out;
    logic [1:0]         status;
    logic               a_is_point;
    logic               a_is_vector;
  } result_t;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [3:0][31:0] a;
    logic [31:0]      f;
    logic [3:0][31:0] r;
    logic [31:0]      sc;
    logic             ovf;
    logic             dz;
    logic             is_pt;
    logic             is_vec;
    logic [65:0]      sv;
    logic [35:0]      srem;
    logic [32:0]      root;
    logic [32:0]      dd;
    logic [3:0][32:0] nl;
    logic [3:0][32:0] drem;
    logic [3:0][32:0] q;
    logic [3:0]       neg;
    logic [3:0]       big;
  } pipe_t;

  // {overflow, value}
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return {1'b1, S32_MAX};
    end else if (v < -66'sd2147483648) begin
      return {1'b1, S32_MIN};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage

// ===== hw/rtl/vec4_arith_unit.sv =====
// An accepted beat passes the front stages, root steps, divider setup, divider steps and result register.
// Throughput: one beat per cycle; a stalled result freezes every stage.
// Depth is set by the 33-step square-root pipeline and the 33-step divider.
// Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
// vec4_arith_unit
// Pipelined four-component fixed-point vector ALU.
// ----------------------------------------------------------------------------
module vec4_arith_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  v4a_pkg::item_t    req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output v4a_pkg::result_t  rsp
);

  logic                                 en;
  logic                                 fr_v;
  v4a_pkg::pipe_t                       fr;
  logic [v4a_pkg::SQRT_STEPS-1:0]       sq_v;
  v4a_pkg::pipe_t                       sq [v4a_pkg::SQRT_STEPS];
  logic                                 su_v;
  v4a_pkg::pipe_t                       su;
  logic [v4a_pkg::DIV_STEPS-1:0]        dv_v;
  v4a_pkg::pipe_t                       dv [v4a_pkg::DIV_STEPS];

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  function automatic v4a_pkg::pipe_t root_step(input v4a_pkg::pipe_t p);
    logic [35:0]    rem2;
    logic [35:0]    trial;
    v4a_pkg::pipe_t o;
    o     = p;
    rem2  = {p.srem[33:0], p.sv[65:64]};
    trial = {1'b0, p.root, 2'b01};
    o.sv  = {p.sv[63:0], 2'b00};
    if (rem2 >= trial) begin
      o.srem = rem2 - trial;
      o.root = {p.root[31:0], 1'b1};
    end else begin
      o.srem = rem2;
      o.root = {p.root[31:0], 1'b0};
    end
    return o;
  endfunction

  function automatic v4a_pkg::pipe_t div_setup(input v4a_pkg::pipe_t p);
    logic [31:0]               absf;
    logic [31:0]               absa;
    logic [v4a_pkg::NUM_W-1:0] nn;
    v4a_pkg::pipe_t            o;
    o    = p;
    absf = p.f[31] ? 32'd0 - p.f : p.f;
    o.dd = {1'b0, absf};
    case (p.cmd) inside
      v4a_pkg::CMD_MAG: begin
        if (p.root > {1'b0, v4a_pkg::S32_MAX}) begin
          o.ovf = 1'b1;
          o.sc  = v4a_pkg::S32_MAX;
        end else begin
          o.sc  = p.root[31:0];
        end
      end
      v4a_pkg::CMD_DIV: begin
        o.dz = (absf == 32'd0);
      end
      v4a_pkg::CMD_NORM: begin
        o.dd = p.root;
        o.dz = (p.root == 33'd0);
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) begin
      absa      = p.a[i][31] ? 32'd0 - p.a[i] : p.a[i];
      nn        = {absa, {v4a_pkg::FRAC_BITS{1'b0}}};
      o.drem[i] = 33'(nn[v4a_pkg::NUM_W-1:33]);
      o.nl[i]   = nn[32:0];
      o.big[i]  = (33'(nn[v4a_pkg::NUM_W-1:32]) >= o.dd);
      o.q[i]    = '0;
      o.neg[i]  = p.a[i][31] ^ ((p.cmd == v4a_pkg::CMD_DIV) && p.f[31]);
    end
    return o;
  endfunction

  function automatic v4a_pkg::pipe_t div_step(input v4a_pkg::pipe_t p);
    logic [33:0]    rem2;
    logic [33:0]    diff;
    v4a_pkg::pipe_t o;
    o = p;
    for (int i = 0; i < 4; i++) begin
      rem2     = {p.drem[i], p.nl[i][32]};
      diff     = rem2 - {1'b0, p.dd};
      o.nl[i]  = {p.nl[i][31:0], 1'b0};
      if (rem2 >= {1'b0, p.dd}) begin
        o.drem[i] = diff[32:0];
        o.q[i]    = {p.q[i][31:0], 1'b1};
      end else begin
        o.drem[i] = rem2[32:0];
        o.q[i]    = {p.q[i][31:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic v4a_pkg::result_t finish(input v4a_pkg::pipe_t p);
    logic [31:0]      r [4];
    logic             ovf;
    logic [32:0]      nq;
    v4a_pkg::result_t o;
    ovf = p.ovf;
    for (int i = 0; i < 4; i++) r[i] = p.r[i];
    if ((p.cmd == v4a_pkg::CMD_DIV) || (p.cmd == v4a_pkg::CMD_NORM)) begin
      for (int i = 0; i < 4; i++) begin
        nq = 33'd0 - p.q[i];
        if (p.dz) begin
          if (p.cmd == v4a_pkg::CMD_NORM || p.a[i] == 32'd0) begin
            r[i] = '0;
          end else begin
            r[i] = p.a[i][31] ? v4a_pkg::S32_MIN : v4a_pkg::S32_MAX;
          end
        end else if (p.neg[i]) begin
          if (p.big[i] || p.q[i] > {1'b0, v4a_pkg::S32_MIN}) begin
            r[i] = v4a_pkg::S32_MIN;
            ovf  = 1'b1;
          end else begin
            r[i] = nq[31:0];
          end
        end else begin
          if (p.big[i] || p.q[i] > {1'b0, v4a_pkg::S32_MAX}) begin
            r[i] = v4a_pkg::S32_MAX;
            ovf  = 1'b1;
          end else begin
            r[i] = p.q[i][31:0];
          end
        end
      end
    end
    o.r_x         = r[0];
    o.r_y         = r[1];
    o.r_z         = r[2];
    o.r_w         = r[3];
    o.scalar_out  = p.sc;
    o.a_is_point  = p.is_pt;
    o.a_is_vector = p.is_vec;
    if (p.dz) begin
      o.status = v4a_pkg::ST_DZ;
    end else if (ovf) begin
      o.status = v4a_pkg::ST_OVF;
    end else begin
      o.status = v4a_pkg::ST_OK;
    end
    return o;
  endfunction

  v4a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .in_item   (req),
    .out_valid (fr_v),
    .out_item  (fr)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= root_step(fr);
      for (int j = 1; j < v4a_pkg::SQRT_STEPS; j++) sq[j] <= root_step(sq[j-1]);
      su    <= div_setup(sq[v4a_pkg::SQRT_STEPS-1]);
      dv[0] <= div_step(su);
      for (int j = 1; j < v4a_pkg::DIV_STEPS; j++) dv[j] <= div_step(dv[j-1]);
      rsp   <= finish(dv[v4a_pkg::DIV_STEPS-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v      <= '0;
      su_v      <= 1'b0;
      dv_v      <= '0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      sq_v      <= {sq_v[v4a_pkg::SQRT_STEPS-2:0], fr_v};
      su_v      <= sq_v[v4a_pkg::SQRT_STEPS-1];
      dv_v      <= {dv_v[v4a_pkg::DIV_STEPS-2:0], su_v};
      rsp_valid <= dv_v[v4a_pkg::DIV_STEPS-1];
    end
  end

endmodule

// ===== hw/rtl/v4a_front.sv =====
// ----------------------------------------------------------------------------
// v4a_front
// Front stages: operand select and multiply, wide sums, shift and saturate.
// ----------------------------------------------------------------------------
module v4a_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  v4a_pkg::item_t  in_item,
  output logic            out_valid,
  output v4a_pkg::pipe_t  out_item
);

  logic signed [31:0] av [4];
  logic signed [31:0] bv [4];
  logic signed [31:0] x0 [4];
  logic signed [31:0] y0 [4];
  logic signed [31:0] x1 [3];
  logic signed [31:0] y1 [3];
  logic signed [32:0] s33 [4];
  logic               lin;
  logic [32:0]        sr;
  v4a_pkg::pipe_t     m;

  logic signed [63:0] p0 [4];
  logic signed [63:0] p1 [3];
  v4a_pkg::pipe_t     m1;
  logic               v1;

  logic signed [65:0] sum;
  logic signed [64:0] dif [3];
  logic signed [63:0] pm [4];
  v4a_pkg::pipe_t     m2;
  logic               v2;

  logic signed [65:0] w66;
  logic [32:0]        sr3;
  v4a_pkg::pipe_t     o;

  always_comb begin
    av[0] = in_item.a_x;
    av[1] = in_item.a_y;
    av[2] = in_item.a_z;
    av[3] = in_item.a_w;
    bv[0] = in_item.b_x;
    bv[1] = in_item.b_y;
    bv[2] = in_item.b_z;
    bv[3] = in_item.b_w;
    m        = '0;
    m.cmd    = in_item.command;
    m.f      = in_item.factor;
    m.is_pt  = (in_item.a_w == v4a_pkg::Q_ONE);
    m.is_vec = (in_item.a_w == 32'sd0);
    lin      = 1'b0;
    sr       = '0;
    for (int i = 0; i < 4; i++) begin
      m.a[i] = av[i];
      x0[i]  = av[i];
      y0[i]  = bv[i];
      s33[i] = '0;
    end
    x1[0] = av[2];
    y1[0] = bv[1];
    x1[1] = av[0];
    y1[1] = bv[2];
    x1[2] = av[1];
    y1[2] = bv[0];
    case (in_item.command) inside
      v4a_pkg::CMD_ADD: begin
        lin = 1'b1;
        for (int i = 0; i < 4; i++) s33[i] = {av[i][31], av[i]} + {bv[i][31], bv[i]};
      end
      v4a_pkg::CMD_SUB: begin
        lin = 1'b1;
        for (int i = 0; i < 4; i++) s33[i] = {av[i][31], av[i]} - {bv[i][31], bv[i]};
      end
      v4a_pkg::CMD_NEG: begin
        lin = 1'b1;
        for (int i = 0; i < 4; i++) s33[i] = 33'sd0 - {av[i][31], av[i]};
      end
      v4a_pkg::CMD_MUL: begin
        for (int i = 0; i < 4; i++) y0[i] = in_item.factor;
      end
      v4a_pkg::CMD_MAG, v4a_pkg::CMD_NORM: begin
        for (int i = 0; i < 4; i++) y0[i] = av[i];
      end
      v4a_pkg::CMD_CROSS: begin
        x0[0] = av[1];
        y0[0] = bv[2];
        x0[1] = av[2];
        y0[1] = bv[0];
        x0[2] = av[0];
        y0[2] = bv[1];
      end
      default: ;
    endcase
    if (lin) begin
      for (int i = 0; i < 4; i++) begin
        sr     = v4a_pkg::sat32({{33{s33[i][32]}}, s33[i]});
        m.r[i] = sr[31:0];
        m.ovf  = m.ovf | sr[32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) p0[i] <= x0[i] * y0[i];
      for (int i = 0; i < 3; i++) p1[i] <= x1[i] * y1[i];
      m1 <= m;
      sum <= {{2{p0[0][63]}}, p0[0]} + {{2{p0[1][63]}}, p0[1]}
           + {{2{p0[2][63]}}, p0[2]} + {{2{p0[3][63]}}, p0[3]};
      for (int i = 0; i < 3; i++) dif[i] <= {p0[i][63], p0[i]} - {p1[i][63], p1[i]};
      for (int i = 0; i < 4; i++) pm[i] <= p0[i];
      m2 <= m1;
      out_item <= o;
    end
  end

  always_comb begin
    o    = m2;
    o.sv = sum;
    w66  = '0;
    sr3  = '0;
    case (m2.cmd) inside
      v4a_pkg::CMD_MUL: begin
        for (int i = 0; i < 4; i++) begin
          w66    = $signed({{2{pm[i][63]}}, pm[i]}) >>> v4a_pkg::FRAC_BITS;
          sr3    = v4a_pkg::sat32(w66);
          o.r[i] = sr3[31:0];
          o.ovf  = o.ovf | sr3[32];
        end
      end
      v4a_pkg::CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          w66    = $signed({dif[i][64], dif[i]}) >>> v4a_pkg::FRAC_BITS;
          sr3    = v4a_pkg::sat32(w66);
          o.r[i] = sr3[31:0];
          o.ovf  = o.ovf | sr3[32];
        end
        o.r[3] = '0;
      end
      v4a_pkg::CMD_DOT: begin
        w66   = sum >>> v4a_pkg::FRAC_BITS;
        sr3   = v4a_pkg::sat32(w66);
        o.sc  = sr3[31:0];
        o.ovf = o.ovf | sr3[32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

// ===== hw/rtl/v4a_chk.sv =====
// ----------------------------------------------------------------------------
// v4a_chk
// Port checker of the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "vec4_arith_unit_assert.svh"

module v4a_chk (
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_stall,
  input v4a_pkg::result_t rsp
);

  `V4A_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result beat changed while stalled")
  `V4A_CHECK(a_flags_excl, rsp_valid, !(rsp.a_is_point && rsp.a_is_vector), "point and vector flags both set")
  `V4A_CHECK(a_scalar_vec, rsp_valid && rsp.scalar_out != 32'sd0, rsp.r_x == 32'sd0 && rsp.r_y == 32'sd0 && rsp.r_z == 32'sd0 && rsp.r_w == 32'sd0, "scalar result with nonzero vector")

endmodule

bind vec4_arith_unit v4a_chk u_chk (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Vector ALU regression
// Drives command beats through the pipelined vector ALU under varying idle and
// stall pressure, predicts every result in fixed point and checks each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class vec_scoreboard;
  v4a_pkg::result_t pending[$];
  int errors;

  function automatic longint floor_sh(longint v);
    return v >>> v4a_pkg::FRAC_BITS;
  endfunction

  function automatic longint clamp(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] length4(longint a[4]);
    logic [63:0] s, m;
    bit all_min;
    s = 0;
    all_min = 1;
    for (int i = 0; i < 4; i++) begin
      m = (a[i] < 0) ? -a[i] : a[i];
      if (a[i] != -64'sd2147483648) all_min = 0;
      s = s + m * m;
    end
    if (all_min) return 64'd1 << 32;
    return root64(s);
  endfunction

  function automatic v4a_pkg::result_t compute(v4a_pkg::item_t it);
    v4a_pkg::result_t res;
    longint a[4], b[4], r[4], f, sc, one, t;
    logic [63:0] m;
    bit ovf, dz;
    one = longint'(1) << v4a_pkg::FRAC_BITS;
    a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z; a[3] = it.a_w;
    b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z; b[3] = it.b_w;
    f = it.factor;
    r = '{0, 0, 0, 0};
    sc = 0;
    ovf = 0;
    dz = 0;
    case (it.command)
      v4a_pkg::CMD_ADD: for (int i = 0; i < 4; i++) r[i] = clamp(a[i] + b[i], ovf);
      v4a_pkg::CMD_SUB: for (int i = 0; i < 4; i++) r[i] = clamp(a[i] - b[i], ovf);
      v4a_pkg::CMD_NEG: for (int i = 0; i < 4; i++) r[i] = clamp(-a[i], ovf);
      v4a_pkg::CMD_MUL: for (int i = 0; i < 4; i++) r[i] = clamp(floor_sh(a[i] * f), ovf);
      v4a_pkg::CMD_DIV:
        for (int i = 0; i < 4; i++) begin
          if (f == 0) begin
            dz = 1;
            r[i] = (a[i] > 0) ? 64'sd2147483647 : (a[i] < 0) ? -64'sd2147483648 : 0;
          end else begin
            r[i] = clamp((a[i] * one) / f, ovf);
          end
        end
      v4a_pkg::CMD_DOT: begin
        // products can reach 2^62 each; sum high and low parts separately
        longint hi, lo, h;
        hi = 0;
        lo = 0;
        for (int i = 0; i < 4; i++) begin
          h = floor_sh(a[i] * b[i]);
          hi += h;
          lo += a[i] * b[i] - h * one;
        end
        sc = clamp(hi + floor_sh(lo), ovf);
      end
      v4a_pkg::CMD_CROSS: begin
        int p[3], q[3];
        longint h1, h2, p1, p2;
        p = '{1, 2, 0};
        q = '{2, 0, 1};
        for (int i = 0; i < 3; i++) begin
          p1 = a[p[i]] * b[q[i]];
          p2 = -(a[q[i]] * b[p[i]]);
          h1 = floor_sh(p1);
          h2 = floor_sh(p2);
          t = h1 + h2 + floor_sh((p1 - h1 * one) + (p2 - h2 * one));
          r[i] = clamp(t, ovf);
        end
      end
      v4a_pkg::CMD_MAG: begin
        m = length4(a);
        if (m > 64'd2147483647) begin
          ovf = 1;
          sc = 64'sd2147483647;
        end else begin
          sc = m;
        end
      end
      v4a_pkg::CMD_NORM: begin
        m = length4(a);
        if (m == 0) dz = 1;
        else for (int i = 0; i < 4; i++) r[i] = clamp((a[i] * one) / longint'(m), ovf);
      end
      default: ;
    endcase
    res.r_x = r[0][31:0];
    res.r_y = r[1][31:0];
    res.r_z = r[2][31:0];
    res.r_w = r[3][31:0];
    res.scalar_out = sc[31:0];
    res.status = dz ? v4a_pkg::ST_DZ : ovf ? v4a_pkg::ST_OVF : v4a_pkg::ST_OK;
    res.a_is_point = (it.a_w == v4a_pkg::Q_ONE);
    res.a_is_vector = (it.a_w == 0);
    return res;
  endfunction

  function void note_item(v4a_pkg::item_t it);
    pending.push_back(compute(it));
  endfunction

  function void check_result(v4a_pkg::result_t got);
    v4a_pkg::result_t exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.r_x !== exp.r_x) begin
      $display("%0t: r_x exp %h got %h", $time, exp.r_x, got.r_x); errors++;
    end
    if (got.r_y !== exp.r_y) begin
      $display("%0t: r_y exp %h got %h", $time, exp.r_y, got.r_y); errors++;
    end
    if (got.r_z !== exp.r_z) begin
      $display("%0t: r_z exp %h got %h", $time, exp.r_z, got.r_z); errors++;
    end
    if (got.r_w !== exp.r_w) begin
      $display("%0t: r_w exp %h got %h", $time, exp.r_w, got.r_w); errors++;
    end
    if (got.scalar_out !== exp.scalar_out) begin
      $display("%0t: scalar_out exp %h got %h", $time, exp.scalar_out, got.scalar_out);
      errors++;
    end
    if (got.status !== exp.status) begin
      $display("%0t: status exp %0d got %0d", $time, exp.status, got.status); errors++;
    end
    if (got.a_is_point !== exp.a_is_point) begin
      $display("%0t: a_is_point exp %b got %b", $time, exp.a_is_point, got.a_is_point);
      errors++;
    end
    if (got.a_is_vector !== exp.a_is_vector) begin
      $display("%0t: a_is_vector exp %b got %b", $time, exp.a_is_vector, got.a_is_vector);
      errors++;
    end
  endfunction
endclass

module testbench;
  import v4a_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  item_t req;
  result_t rsp;

  int send_idle_pct, recv_stall_pct, quiet_cycles;
  vec_scoreboard vec_board;

  vec4_arith_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) vec_board.check_result(rsp);
    rsp_stall <= (int'($urandom_range(99)) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] pick_num();
    case ($urandom_range(7))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return 0;
      3: return Q_ONE;
      4: return $urandom_range(1 << 20) - (1 << 19);
      5: return $urandom_range(1 << 24) - (1 << 23);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(item_t it);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req <= it;
    req_valid <= 1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    vec_board.note_item(it);
  endtask

  task automatic send_random(int count);
    item_t it;
    for (int n = 0; n < count; n++) begin
      it.command = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                              : 4'($urandom_range(CMD_NORM));
      it.a_x = pick_num(); it.a_y = pick_num(); it.a_z = pick_num();
      it.a_w = pick_num();
      it.b_x = pick_num(); it.b_y = pick_num(); it.b_z = pick_num();
      it.b_w = pick_num();
      it.factor = pick_num();
      send_beat(it);
    end
  endtask

  task automatic drain();
    req_valid <= 0;
    while (vec_board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic directed();
    item_t it;
    logic [31:0] vals[5];
    vals = '{S32_MAX, S32_MIN, 0, Q_ONE, 32'hFFFF_FFFF};
    for (int c = 0; c <= int'(CMD_NORM); c++) begin
      it = '{command: 4'(c), a_x: S32_MAX, a_y: S32_MIN, a_z: S32_MAX, a_w: Q_ONE,
             b_x: S32_MIN, b_y: S32_MAX, b_z: S32_MIN, b_w: 32'hFFFF_FFFF, factor: 0};
      send_beat(it);
    end
    it = '{CMD_MAG, S32_MIN, S32_MIN, S32_MIN, S32_MIN, 0, 0, 0, 0, 0};
    send_beat(it);
    it.command = CMD_NORM;
    send_beat(it);
    it = '{CMD_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_beat(it);
    it = '{CMD_NEG, S32_MIN, 0, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0};
    send_beat(it);
    it = '{CMD_DIV, 5, -5, 0, Q_ONE, 0, 0, 0, 0, 0};
    send_beat(it);
    it = '{CMD_DIV, S32_MAX, S32_MIN, 1, 0, 0, 0, 0, 0, 1};
    send_beat(it);
    it = '{CMD_MUL, -1, 3, S32_MIN, S32_MAX, 0, 0, 0, 0, S32_MIN};
    send_beat(it);
    it = '{CMD_DOT, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN,
           S32_MIN, 0};
    send_beat(it);
    it = '{4'd9, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_beat(it);
    it = '{4'd15, 1, 2, 3, Q_ONE, 0, 0, 0, 0, 0};
    send_beat(it);
    for (int i = 0; i < 5; i++) begin
      it = '{CMD_ADD, vals[i], vals[i], vals[i], vals[i], vals[(i + 1) % 5],
             vals[(i + 2) % 5], vals[i], vals[i], vals[i]};
      send_beat(it);
    end
  endtask

  initial begin
    vec_board = new();
    rst = 1;
    req_valid = 0;
    req = '0;
    rsp_stall = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    directed();
    send_random(250);
    drain();
    send_idle_pct = 81;
    send_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    send_random(200);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    send_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(180);

    drain();
    repeat (100) @(posedge clk);
    if (vec_board.errors == 0 && vec_board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
